[rtl/core/assert_macros.svh]
// Assertion macros shared by the RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

[rtl/core/rabbit_pkg.sv]
// Rabbit cipher package: types, constants and helper functions (counter constants, rotations).
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rabbit_pkg;

	typedef enum logic [1:0] {
		REG_KEY_LOW  = 2'd0,
		REG_KEY_HIGH = 2'd1,
		REG_IV       = 2'd2,
		REG_USE_IV   = 2'd3
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD,
		ST_CTR,
		ST_G,
		ST_G_WAIT,
		ST_MIX,
		ST_KEYFIX,
		ST_IVMIX,
		ST_BUILD,
		ST_OUT
	} rb_state_t;

	typedef logic [31:0] word_t;

	// Control word from sequencer to the step unit
	typedef struct packed {
		logic load;
		logic ctr;
		logic g_start;
		logic mix;
		logic keyfix;
		logic ivmix;
	} rb_ctl_t;

	localparam word_t A0 = 32'h4D34D34D;
	localparam word_t A1 = 32'hD34D34D3;
	localparam word_t A2 = 32'h34D34D34;

	function automatic word_t a_const(input logic [2:0] i);
		word_t r;
		unique case (i)
			3'd0, 3'd3, 3'd6: r = A0;
			3'd1, 3'd4, 3'd7: r = A1;
			default:          r = A2;
		endcase
		return r;
	endfunction

	function automatic word_t rotl16(input word_t v);
		return {v[15:0], v[31:16]};
	endfunction

	function automatic word_t rotl8(input word_t v);
		return {v[23:0], v[31:24]};
	endfunction

endpackage
`default_nettype wire

[rtl/core/rabbit_sq.sv]
// Shared squaring unit: one 32x32 square, registered input and square, combinational fold.
// Depends on rabbit_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rabbit_sq (
	input  wire                  clk,
	input  wire rabbit_pkg::word_t opnd,
	output rabbit_pkg::word_t    g
);
	rabbit_pkg::word_t u_q;
	logic [63:0]       sq_q;

	// operand reg, square reg, fold
	always_ff @(posedge clk) begin
		u_q  <= opnd;
		sq_q <= u_q * u_q;
	end

	assign g = sq_q[31:0] ^ sq_q[63:32];
endmodule
`default_nettype wire

[rtl/core/rabbit_stream_cipher_top.sv]
// Rabbit stream cipher top: sequencer, state registers, keystream block.
// Depends on rabbit_pkg, rabbit_sq and assert_macros.svh.
//
// Channel | Direction | Signals
// in      | input     | valid, ready, op, data_byte, last_byte
// out     | output    | out_valid, out_ready, out_byte, last_out
// cfg     | input     | cfg_we, cfg_idx, cfg_data
//
// One squaring unit serves all eight g words, one word a cycle, through its operand and square registers.
// Advance: counter update for each word, g issue for each word, drain, then mix.
// Start item: load + 4 advances + key fixup; with use_iv, the IV mix and 4 more advances follow.
// Data byte: accepted in idle, sent out from ST_OUT, then held until the result
// is taken; a new block first costs an advance and a build.
// Input is not ready while an item is at work or a result waits to be taken.
// Reset clears state words, counters, carry and byte position.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module rabbit_stream_cipher_top (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         valid,
	output logic        ready,
	input  wire         op,
	input  wire  [7:0]  data_byte,
	input  wire         last_byte,
	output logic        out_valid,
	input  wire         out_ready,
	output logic [7:0]  out_byte,
	output logic        last_out,
	input  wire         cfg_we,
	input  wire  [1:0]  cfg_idx,
	input  wire  [63:0] cfg_data
);
	// configuration registers
	logic [63:0] key_low_q, key_high_q, iv_q;
	logic        use_iv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q  <= '0;
			key_high_q <= '0;
			iv_q       <= '0;
			use_iv_q   <= 1'b1;
		end else if (cfg_we) begin
			unique case (rabbit_pkg::reg_idx_t'(cfg_idx))
				rabbit_pkg::REG_KEY_LOW:  key_low_q  <= cfg_data;
				rabbit_pkg::REG_KEY_HIGH: key_high_q <= cfg_data;
				rabbit_pkg::REG_IV:       iv_q       <= cfg_data;
				rabbit_pkg::REG_USE_IV:   use_iv_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	rabbit_pkg::rb_state_t st_q, st_d;
	rabbit_pkg::rb_ctl_t   ctl;
	logic [2:0]  idx_q;        // word index for counter / g loops
	logic [1:0]  gdly_q;       // drain counter
	logic [2:0]  adv_q;        // advances left in a setup phase
	logic        setup_q;      // item is a start
	logic        ivphase_q;
	logic [3:0]  pos_q;
	logic [7:0]  dbyte_q;
	logic        dlast_q;

	rabbit_pkg::word_t x_q [8];
	rabbit_pkg::word_t c_q [8];
	rabbit_pkg::word_t gw_q [8];
	logic              carry_q;
	logic [15:0]       ks_q [8];

	// square unit, operand chosen by index
	rabbit_pkg::word_t sq_in, g_out;
	logic [2:0]        gidx_s1, gidx_s2;
	logic              gv_s1, gv_s2;
	assign sq_in = x_q[idx_q] + c_q[idx_q];
	rabbit_sq u_sq (.clk(clk), .opnd(sq_in), .g(g_out));

	// key words
	logic [15:0] k [8];
	always_comb begin
		for (int j = 0; j < 4; j++) begin
			k[j]   = key_low_q[16*j +: 16];
			k[j+4] = key_high_q[16*j +: 16];
		end
	end

	// IV words
	rabbit_pkg::word_t i0, i1, i2, i3;
	assign i0 = iv_q[31:0];
	assign i2 = iv_q[63:32];
	assign i1 = {i2[31:16], i0[31:16]};
	assign i3 = {i2[15:0], i0[15:0]};

	// counter add for current index
	logic [32:0] ctr_sum;
	assign ctr_sum = {1'b0, c_q[idx_q]} + {1'b0, rabbit_pkg::a_const(idx_q)}
		+ {32'd0, carry_q};

	assign ready = (st_q == rabbit_pkg::ST_IDLE) && !out_valid;

	// sequencer: next state and control
	always_comb begin
		st_d = st_q;
		ctl  = '0;
		unique case (st_q)
			rabbit_pkg::ST_IDLE: begin
				if (valid && ready)
					st_d = op ? ((pos_q == 4'd0) ? rabbit_pkg::ST_CTR : rabbit_pkg::ST_OUT)
						: rabbit_pkg::ST_LOAD;
			end
			rabbit_pkg::ST_LOAD: begin
				ctl.load = 1'b1;
				st_d     = rabbit_pkg::ST_CTR;
			end
			rabbit_pkg::ST_CTR: begin
				ctl.ctr = 1'b1;
				if (idx_q == 3'd7) st_d = rabbit_pkg::ST_G;
			end
			rabbit_pkg::ST_G: begin
				ctl.g_start = 1'b1;
				if (idx_q == 3'd7) st_d = rabbit_pkg::ST_G_WAIT;
			end
			rabbit_pkg::ST_G_WAIT: begin
				if (gdly_q == 2'd2) st_d = rabbit_pkg::ST_MIX;
			end
			rabbit_pkg::ST_MIX: begin
				ctl.mix = 1'b1;
				if (!setup_q)            st_d = rabbit_pkg::ST_BUILD;
				else if (adv_q != 3'd1)  st_d = rabbit_pkg::ST_CTR;
				else if (ivphase_q)      st_d = rabbit_pkg::ST_IDLE;
				else                     st_d = rabbit_pkg::ST_KEYFIX;
			end
			rabbit_pkg::ST_KEYFIX: begin
				ctl.keyfix = 1'b1;
				st_d = use_iv_q ? rabbit_pkg::ST_IVMIX : rabbit_pkg::ST_IDLE;
			end
			rabbit_pkg::ST_IVMIX: begin
				ctl.ivmix = 1'b1;
				st_d      = rabbit_pkg::ST_CTR;
			end
			rabbit_pkg::ST_BUILD: st_d = rabbit_pkg::ST_OUT;
			rabbit_pkg::ST_OUT:   st_d = rabbit_pkg::ST_IDLE;
			default:              st_d = rabbit_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= rabbit_pkg::ST_IDLE;
		else         st_q <= st_d;
	end

	// control counters and flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			gdly_q    <= '0;
			adv_q     <= '0;
			setup_q   <= 1'b0;
			ivphase_q <= 1'b0;
			gv_s1     <= 1'b0;
			gv_s2     <= 1'b0;
			out_valid <= 1'b0;
			pos_q     <= '0;
			carry_q   <= 1'b0;
		end else begin
			gv_s1 <= ctl.g_start;
			gv_s2 <= gv_s1;
			if (ctl.ctr || ctl.g_start) idx_q <= idx_q + 3'd1;
			if (st_q == rabbit_pkg::ST_G_WAIT) gdly_q <= gdly_q + 2'd1;
			else                               gdly_q <= '0;
			if (ctl.ctr) carry_q <= ctr_sum[32];
			if (valid && ready) setup_q <= !op;
			if (ctl.load) begin
				adv_q     <= 3'd4;
				ivphase_q <= 1'b0;
				carry_q   <= 1'b0;
				pos_q     <= '0;
			end
			if (ctl.mix && setup_q) adv_q <= adv_q - 3'd1;
			if (ctl.ivmix) begin
				adv_q     <= 3'd4;
				ivphase_q <= 1'b1;
			end
			if (st_q == rabbit_pkg::ST_OUT) begin
				out_valid <= 1'b1;
				pos_q     <= pos_q + 4'd1;
			end else if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	// g index pipeline and input byte capture
	always_ff @(posedge clk) begin
		gidx_s1 <= idx_q;
		gidx_s2 <= gidx_s1;
		if (gv_s2) gw_q[gidx_s2] <= g_out;
		if (valid && ready) begin
			dbyte_q <= data_byte;
			dlast_q <= last_byte;
		end
	end

	// state and counter words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < 8; j++) begin
				x_q[j] <= '0;
				c_q[j] <= '0;
			end
		end else begin
			if (ctl.load) begin
				for (int j = 0; j < 8; j++) begin
					if ((j & 1) == 0) begin
						x_q[j] <= {k[(j+1)&7], k[j]};
						c_q[j] <= {k[(j+4)&7], k[(j+5)&7]};
					end else begin
						x_q[j] <= {k[(j+5)&7], k[(j+4)&7]};
						c_q[j] <= {k[j], k[(j+1)&7]};
					end
				end
			end
			if (ctl.ctr) c_q[idx_q] <= ctr_sum[31:0];
			if (ctl.mix) begin
				for (int j = 0; j < 8; j += 2) begin
					x_q[j]   <= gw_q[j] + rabbit_pkg::rotl16(gw_q[(j+7)&7])
						+ rabbit_pkg::rotl16(gw_q[(j+6)&7]);
					x_q[j+1] <= gw_q[j+1] + rabbit_pkg::rotl8(gw_q[j]) + gw_q[(j+7)&7];
				end
			end
			if (ctl.keyfix)
				for (int j = 0; j < 8; j++) c_q[j] <= c_q[j] ^ x_q[(j+4)&7];
			if (ctl.ivmix) begin
				c_q[0] <= c_q[0] ^ i0;
				c_q[1] <= c_q[1] ^ i1;
				c_q[2] <= c_q[2] ^ i2;
				c_q[3] <= c_q[3] ^ i3;
				c_q[4] <= c_q[4] ^ i0;
				c_q[5] <= c_q[5] ^ i1;
				c_q[6] <= c_q[6] ^ i2;
				c_q[7] <= c_q[7] ^ i3;
			end
		end
	end

	// keystream block build
	always_ff @(posedge clk) begin
		if (st_q == rabbit_pkg::ST_BUILD) begin
			ks_q[0] <= x_q[0][15:0]  ^ x_q[5][31:16];
			ks_q[1] <= x_q[0][31:16] ^ x_q[3][15:0];
			ks_q[2] <= x_q[2][15:0]  ^ x_q[7][31:16];
			ks_q[3] <= x_q[2][31:16] ^ x_q[5][15:0];
			ks_q[4] <= x_q[4][15:0]  ^ x_q[1][31:16];
			ks_q[5] <= x_q[4][31:16] ^ x_q[7][15:0];
			ks_q[6] <= x_q[6][15:0]  ^ x_q[3][31:16];
			ks_q[7] <= x_q[6][31:16] ^ x_q[1][15:0];
		end
	end

	// output word
	logic [15:0] ks_word;
	assign ks_word = ks_q[pos_q[3:1]];
	always_ff @(posedge clk) begin
		if (st_q == rabbit_pkg::ST_OUT) begin
			out_byte <= dbyte_q ^ (pos_q[0] ? ks_word[15:8] : ks_word[7:0]);
			last_out <= dlast_q;
		end
	end

	`ASSERT_IMPL(a_no_ready_busy, clk, arst_n, st_q != rabbit_pkg::ST_IDLE, !ready)
	`ASSERT_NEXT(a_out_after_out, clk, arst_n, st_q == rabbit_pkg::ST_OUT, out_valid)
	`ASSERT_IMPL(a_g_in_wait, clk, arst_n, ctl.mix, !gv_s1 && !gv_s2)
endmodule
`default_nettype wire
